>>> src/hsd_pkg.sv
// Shared types and constants for the descending heap sort core.
// No dependencies; used by hsd_seq, hsd_ram and heap_sort_descending_core.

package hsd_pkg;

   // Width of one stored element and default store depth.
   localparam int DATA_W           = 32;
   localparam int CAPACITY_DEFAULT = 64;

   // One result word handed from the sequencer to the output register.
   typedef struct packed {
      logic                     valid;
      logic signed [DATA_W-1:0] value;
      logic                     end_of_run;
      logic                     overflow;
   } emit_type;

endpackage

>>> src/heap_sort_descending_core.sv
// Descending heap sort core: while loading, input words load one per cycle; a word with
// last set starts an in-place heapsort of the stored words through the single write port
// of the element store. Results then leave one word per cycle while rsp_ready stays high,
// largest first, via an output register.
// Synchronous active-high reset clears the count, overflow flag and control state;
// the element store is not cleared and needs no clearing pass.

module heap_sort_descending_core #(
   parameter int CAPACITY = hsd_pkg::CAPACITY_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [hsd_pkg::DATA_W-1:0] req_value,
   input  logic                              req_last,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [hsd_pkg::DATA_W-1:0] rsp_sorted_value,
   output logic                              rsp_end_of_run,
   output logic                              rsp_overflow
);

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   hsd_pkg::emit_type                 emit;
   logic                              emit_free;
   logic                              mem_we;
   logic [IDX_W-1:0]                  mem_waddr, mem_raddr_a, mem_raddr_b;
   logic signed [hsd_pkg::DATA_W-1:0] mem_wdata, mem_rdata_a, mem_rdata_b;

   logic                              rsp_valid_ff;
   logic signed [hsd_pkg::DATA_W-1:0] rsp_value_ff;
   logic                              rsp_eor_ff;
   logic                              rsp_ovf_ff;

   hsd_ram #(
      .DEPTH (CAPACITY),
      .IDX_W (IDX_W)
   ) u_ram (
      .clock   (clock),
      .we      (mem_we),
      .waddr   (mem_waddr),
      .wdata   (mem_wdata),
      .raddr_a (mem_raddr_a),
      .raddr_b (mem_raddr_b),
      .rdata_a (mem_rdata_a),
      .rdata_b (mem_rdata_b)
   );

   hsd_seq #(
      .CAPACITY (CAPACITY),
      .IDX_W    (IDX_W),
      .CNT_W    (CNT_W)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_value   (req_value),
      .req_last    (req_last),
      .emit        (emit),
      .emit_free   (emit_free),
      .mem_we      (mem_we),
      .mem_waddr   (mem_waddr),
      .mem_wdata   (mem_wdata),
      .mem_raddr_a (mem_raddr_a),
      .mem_raddr_b (mem_raddr_b),
      .mem_rdata_a (mem_rdata_a),
      .mem_rdata_b (mem_rdata_b)
   );

   // The output register can take a word when empty or being drained.
   assign emit_free = !rsp_valid_ff || rsp_ready;

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (emit.valid) begin
         rsp_value_ff <= emit.value;
         rsp_eor_ff   <= emit.end_of_run;
         rsp_ovf_ff   <= emit.overflow;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_run   = rsp_eor_ff;
   assign rsp_overflow     = rsp_ovf_ff;

`ifndef NO_ASSERTIONS
   // A result word is only pushed when the output register has room.
   a_emit_room: assert property (@(posedge clock) disable iff (reset)
      emit.valid |-> emit_free)
      else $error("result word pushed into a full output register");

   // No result is produced while input words are being loaded.
   a_no_emit_in_load: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !emit.valid)
      else $error("result word produced during loading");

   // The last word of a run returns the core to loading.
   a_reload_after_run: assert property (@(posedge clock) disable iff (reset)
      (emit.valid && emit.end_of_run) |=> req_ready)
      else $error("core not ready for loading after end of run");
`endif

endmodule

>>> src/hsd_ram.sv
// Element store: one write port, two synchronous read ports, read data registered.
// A read of the entry being written in the same cycle returns the new data.
// Depends on hsd_pkg for the data width and the default depth.

module hsd_ram #(
   parameter int DEPTH = hsd_pkg::CAPACITY_DEFAULT,
   parameter int IDX_W = $clog2(DEPTH)
) (
   input  logic                            clock,
   input  logic                            we,
   input  logic [IDX_W-1:0]                waddr,
   input  logic signed [hsd_pkg::DATA_W-1:0] wdata,
   input  logic [IDX_W-1:0]                raddr_a,
   input  logic [IDX_W-1:0]                raddr_b,
   output logic signed [hsd_pkg::DATA_W-1:0] rdata_a,
   output logic signed [hsd_pkg::DATA_W-1:0] rdata_b
);

   logic signed [hsd_pkg::DATA_W-1:0] mem [DEPTH];
   logic signed [hsd_pkg::DATA_W-1:0] rdata_a_ff;
   logic signed [hsd_pkg::DATA_W-1:0] rdata_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read ports with write-first forwarding.
   always_ff @(posedge clock) begin
      if (we && (waddr == raddr_a)) begin
         rdata_a_ff <= wdata;
      end else begin
         rdata_a_ff <= mem[raddr_a];
      end
      if (we && (waddr == raddr_b)) begin
         rdata_b_ff <= wdata;
      end else begin
         rdata_b_ff <= mem[raddr_b];
      end
   end

   assign rdata_a = rdata_a_ff;
   assign rdata_b = rdata_b_ff;

endmodule

>>> src/hsd_seq.sv
// Sequencer of the heap sort: loads words, builds the max-heap, extracts the
// root repeatedly with a hole-based sift-down, then streams results out.
// Depends on hsd_pkg; drives the ports of hsd_ram.

module hsd_seq #(
   parameter int CAPACITY = hsd_pkg::CAPACITY_DEFAULT,
   parameter int IDX_W    = $clog2(CAPACITY),
   parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [hsd_pkg::DATA_W-1:0] req_value,
   input  logic                              req_last,
   output hsd_pkg::emit_type                 emit,
   input  logic                              emit_free,
   output logic                              mem_we,
   output logic [IDX_W-1:0]                  mem_waddr,
   output logic signed [hsd_pkg::DATA_W-1:0] mem_wdata,
   output logic [IDX_W-1:0]                  mem_raddr_a,
   output logic [IDX_W-1:0]                  mem_raddr_b,
   input  logic signed [hsd_pkg::DATA_W-1:0] mem_rdata_a,
   input  logic signed [hsd_pkg::DATA_W-1:0] mem_rdata_b
);

   // Child indices need two bits more than a node index.
   localparam int CW = IDX_W + 2;

   typedef enum logic [2:0] {
      S_LOAD,
      S_BUILD_NV,
      S_SWAP_WR,
      S_EVAL,
      S_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [CNT_W-1:0]                  count_ff, count_in;
   logic                              drop_ff, drop_in;
   logic [IDX_W-1:0]                  node_ff, node_in;
   logic [IDX_W-1:0]                  idx_ff, idx_in;
   logic signed [hsd_pkg::DATA_W-1:0] nv_ff, nv_in;
   logic                              build_ff, build_in;

   logic [CW-1:0] left_cur, right_cur, left_next, right_next, size_cur;
   logic          left_ok, right_ok, take_left, take_right;

   // Children of the node under evaluation and of the node evaluated next.
   assign left_cur   = {1'b0, node_ff, 1'b1};
   assign right_cur  = left_cur + 1'b1;
   assign left_next  = {1'b0, node_in, 1'b1};
   assign right_next = left_next + 1'b1;

   // Heap size is the element count while building, the sort index afterwards.
   assign size_cur = build_ff ? CW'(count_ff) : CW'(idx_ff);
   assign left_ok  = left_cur < size_cur;
   assign right_ok = right_cur < size_cur;

   // Pick the larger child if it beats the held value; ties keep the left one.
   always_comb begin
      take_left  = left_ok && (mem_rdata_a > nv_ff);
      take_right = 1'b0;
      if (right_ok) begin
         if (take_left) begin
            take_right = mem_rdata_b > mem_rdata_a;
         end else begin
            take_right = mem_rdata_b > nv_ff;
         end
      end
   end

   // Next state and memory write.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      drop_in   = drop_ff;
      node_in   = node_ff;
      idx_in    = idx_ff;
      nv_in     = nv_ff;
      build_in  = build_ff;
      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      emit      = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (count_ff < CNT_W'(CAPACITY)) begin
                  mem_we    = 1'b1;
                  mem_waddr = count_ff[IDX_W-1:0];
                  mem_wdata = req_value;
                  count_in  = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_last) begin
                  if (count_in < CNT_W'(2)) begin
                     idx_in   = '0;
                     state_in = S_EMIT;
                  end else begin
                     // While building, idx holds the node whose sift-down is running.
                     build_in = 1'b1;
                     node_in  = IDX_W'((count_in >> 1) - 1'b1);
                     idx_in   = IDX_W'((count_in >> 1) - 1'b1);
                     state_in = S_BUILD_NV;
                  end
               end
            end
         end

         S_BUILD_NV: begin
            nv_in    = mem_rdata_a;
            state_in = S_EVAL;
         end

         // Root goes to the end of the heap; the old last entry is sifted from the root.
         S_SWAP_WR: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff;
            mem_wdata = mem_rdata_a;
            nv_in     = mem_rdata_b;
            node_in   = '0;
            state_in  = S_EVAL;
         end

         S_EVAL: begin
            mem_we    = 1'b1;
            mem_waddr = node_ff;
            if (take_right) begin
               mem_wdata = mem_rdata_b;
               node_in   = right_cur[IDX_W-1:0];
            end else if (take_left) begin
               mem_wdata = mem_rdata_a;
               node_in   = left_cur[IDX_W-1:0];
            end else begin
               mem_wdata = nv_ff;
               if (build_ff) begin
                  if (idx_ff == '0) begin
                     build_in = 1'b0;
                     idx_in   = IDX_W'(count_ff - 1'b1);
                     state_in = S_SWAP_WR;
                  end else begin
                     idx_in   = idx_ff - 1'b1;
                     node_in  = idx_ff - 1'b1;
                     state_in = S_BUILD_NV;
                  end
               end else if (idx_ff == IDX_W'(1)) begin
                  idx_in   = IDX_W'(count_ff - 1'b1);
                  state_in = S_EMIT;
               end else begin
                  idx_in   = idx_ff - 1'b1;
                  state_in = S_SWAP_WR;
               end
            end
         end

         // The array is ascending now: emit from the top index down to zero.
         S_EMIT: begin
            if (emit_free) begin
               emit.valid      = 1'b1;
               emit.value      = mem_rdata_a;
               emit.end_of_run = (idx_ff == '0);
               emit.overflow   = drop_ff;
               if (idx_ff == '0) begin
                  count_in = '0;
                  drop_in  = 1'b0;
                  state_in = S_LOAD;
               end else begin
                  idx_in = idx_ff - 1'b1;
               end
            end
         end
      endcase
   end

   // Read addresses are set up in the cycle before the state that uses the data.
   always_comb begin
      mem_raddr_a = '0;
      mem_raddr_b = '0;
      unique case (state_in)
         S_LOAD: begin
            mem_raddr_a = '0;
         end
         S_BUILD_NV: begin
            mem_raddr_a = node_in;
         end
         S_SWAP_WR: begin
            mem_raddr_a = '0;
            mem_raddr_b = idx_in;
         end
         S_EVAL: begin
            mem_raddr_a = left_next[IDX_W-1:0];
            mem_raddr_b = right_next[IDX_W-1:0];
         end
         S_EMIT: begin
            mem_raddr_a = idx_in;
         end
      endcase
   end

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         drop_ff  <= 1'b0;
         build_ff <= 1'b0;
         node_ff  <= '0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff  <= drop_in;
         build_ff <= build_in;
         node_ff  <= node_in;
         idx_ff   <= idx_in;
      end
      nv_ff <= nv_in;
   end

endmodule
